// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, ignored while reset is high.
`define ASSERT_HOLDS(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_HOLDS(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/p2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// p2rgb_pkg
// Types, constants and helpers for the pixel to RGB888 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package p2rgb_pkg;

  typedef enum logic {
    MODE_RGB565 = 1'b0,
    MODE_YCBCR  = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] packed_565;
    logic [7:0]  luma;
    logic [7:0]  chroma_red;
    logic [7:0]  chroma_blue;
    logic        row_end;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end_out;
  } pixel_out_t;

  // RGB565 expansion: floor(v*255/max) as (v * (255*K)) >> S, with K a
  // rounded-up reciprocal of max that stays exact over the whole input range.
  localparam int EXP5_SHIFT = 18;
  localparam int EXP5_PROD_W = 27;
  localparam logic [EXP5_PROD_W-1:0] EXP5_MUL = 27'd2156535; // 255 * 8457
  localparam int EXP6_SHIFT = 20;
  localparam int EXP6_PROD_W = 29;
  localparam logic [EXP6_PROD_W-1:0] EXP6_MUL = 29'd4244475; // 255 * 16645

  // YCbCr path: 16 fractional bits, signed accumulator wide enough for
  // 255*2^16 plus the largest chroma term.
  localparam int FRAC_W = 16;
  localparam int ACC_W  = 27;
  localparam logic signed [ACC_W-1:0] COEF_R_CR = 27'sd91881;
  localparam logic signed [ACC_W-1:0] COEF_G_CB = 27'sd22554;
  localparam logic signed [ACC_W-1:0] COEF_G_CR = 27'sd46802;
  localparam logic signed [ACC_W-1:0] COEF_B_CB = 27'sd116130;

  // Floor the fixed-point value and clamp to 0..255.
  function automatic logic [7:0] sat_floor(input logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[ACC_W-1]) begin
      res = 8'd0;
    end else if (|acc[ACC_W-2:FRAC_W+8]) begin
      res = 8'hff;
    end else begin
      res = acc[FRAC_W +: 8];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/p2rgb_convert.sv -----
// ----------------------------------------------------------------------------
// p2rgb_convert
// Combinational color conversion of one held pixel to RGB888.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module p2rgb_convert (
  input  var p2rgb_pkg::pixel_in_t  pix,
  output var p2rgb_pkg::pixel_out_t rgb
);
  import p2rgb_pkg::*;

  logic [EXP5_PROD_W-1:0] r565_prod;
  logic [EXP6_PROD_W-1:0] g565_prod;
  logic [EXP5_PROD_W-1:0] b565_prod;

  logic signed [7:0]       cr_off;
  logic signed [7:0]       cb_off;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_g;
  logic signed [ACC_W-1:0] acc_b;

  // RGB565 expansion by reciprocal multiply
  assign r565_prod = EXP5_PROD_W'(pix.packed_565[15:11]) * EXP5_MUL;
  assign g565_prod = EXP6_PROD_W'(pix.packed_565[10:5]) * EXP6_MUL;
  assign b565_prod = EXP5_PROD_W'(pix.packed_565[4:0]) * EXP5_MUL;

  // Remove the 128 chroma offset: flipping the top bit gives the signed value
  assign cr_off = $signed({~pix.chroma_red[7], pix.chroma_red[6:0]});
  assign cb_off = $signed({~pix.chroma_blue[7], pix.chroma_blue[6:0]});
  assign base   = $signed({3'b000, pix.luma, 16'h0000});

  assign acc_r = base + ACC_W'(cr_off) * COEF_R_CR;
  assign acc_g = base - ACC_W'(cb_off) * COEF_G_CB - ACC_W'(cr_off) * COEF_G_CR;
  assign acc_b = base + ACC_W'(cb_off) * COEF_B_CB;

  always_comb begin
    case (pix.mode)
      MODE_RGB565: begin
        rgb.red   = r565_prod[EXP5_SHIFT +: 8];
        rgb.green = g565_prod[EXP6_SHIFT +: 8];
        rgb.blue  = b565_prod[EXP5_SHIFT +: 8];
      end
      MODE_YCBCR: begin
        rgb.red   = sat_floor(acc_r);
        rgb.green = sat_floor(acc_g);
        rgb.blue  = sat_floor(acc_b);
      end
      default: begin
        rgb.red   = 8'd0;
        rgb.green = 8'd0;
        rgb.blue  = 8'd0;
      end
    endcase
    rgb.row_end_out = pix.row_end;
  end

endmodule

`default_nettype wire

// ----- src/pixel_to_rgb888_converter_unit.sv -----
// ----------------------------------------------------------------------------
// pixel_to_rgb888_converter_unit
// Converts RGB565 or full-range BT.601 YCbCr pixels to saturated RGB888.
// ----------------------------------------------------------------------------
// One pixel per clock while the rgb side is not stalled. A transaction on
// the pix channel is captured in an input register, converted by constant
// multiplies and adds, and lands in the output register that drives the
// rgb channel, so both registers can hold pixels at once. Mode 0
// expands an RGB565 word with value*255/max truncation per channel; mode 1
// converts Y, Cr, Cb with 16-bit fractional coefficients, floors, and
// clamps each channel to 0..255. row_end rides along unchanged. pix_stall
// rises only when both registers are full and the rgb side is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_to_rgb888_converter_unit (
  input  var logic                  clk,
  input  var logic                  rst,
  input  var logic                  pix_valid,
  output var logic                  pix_stall,
  input  var p2rgb_pkg::pixel_in_t  pix,
  output var logic                  rgb_valid,
  input  var logic                  rgb_stall,
  output var p2rgb_pkg::pixel_out_t rgb
);
  import p2rgb_pkg::*;

  `include "assert_macros.svh"

  // Input register
  logic       held_valid;
  pixel_in_t  held;

  // Conversion result ahead of the output register
  pixel_out_t conv;

  logic advance;
  logic pix_take;

  // Output register moves when empty or when the consumer takes it
  assign advance   = !rgb_valid || !rgb_stall;
  // Hold the input side only when the held pixel cannot move on
  assign pix_stall = held_valid && !advance;
  assign pix_take  = pix_valid && !pix_stall;

  p2rgb_convert u_convert (
    .pix (held),
    .rgb (conv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      rgb_valid  <= 1'b0;
    end else begin
      if (!pix_stall) begin
        held_valid <= pix_valid;
      end
      if (advance) begin
        rgb_valid <= held_valid;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (pix_take) begin
      held <= pix;
    end
    if (advance && held_valid) begin
      rgb <= conv;
    end
  end

  // Accepted transaction occupies the input register next cycle
  `ASSERT_NEXT(a_take_fills, clk, rst, pix_take, held_valid)
  // Both stages full and stalled downstream: back-pressure the input
  `ASSERT_HOLDS(a_full_stalls, clk, rst, rgb_valid && rgb_stall && held_valid, pix_stall)
  // A held pixel that advances shows up as a result with its row flag
  `ASSERT_NEXT(a_row_end_kept, clk, rst, advance && held_valid, rgb_valid && (rgb.row_end_out == $past(held.row_end)))
  // Full-scale RGB565 red expands to full-scale 8-bit red
  `ASSERT_NEXT(a_red_full, clk, rst, advance && held_valid && (held.mode == MODE_RGB565) && (held.packed_565[15:11] == 5'h1f), rgb.red == 8'hff)

endmodule

`default_nettype wire
